FILE: sv/grr_pkg.sv
`default_nettype none

package grr_pkg;

    localparam int MAX_RAMP = 64;
    localparam int IDX_W    = $clog2(MAX_RAMP);
    localparam int LEN_W    = 7;
    localparam int POS_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int COL_W    = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = COL_W / CH_W;
    localparam int CH_SEL_W = $clog2(NUM_CH);
    localparam int NUM_W    = CH_W + IDX_W;
    localparam int PROD_W   = POS_W + IDX_W + 1;
    localparam int STEP_W   = $clog2(CH_W);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [CH_W-1:0]   t_ch;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [PROD_W-1:0] t_prod;

    localparam t_pos POS_ONE   = t_pos'(1 << FRAC_W);
    localparam t_len LEN_RESET = t_len'(64);
    localparam t_len LEN_MAX   = t_len'(MAX_RAMP);
    localparam t_len LEN_MIN   = t_len'(1);
    localparam t_prod HALF     = t_prod'(1 << (FRAC_W - 1));

    typedef struct packed {
        logic start;
        t_num num;
        t_idx den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_ch  quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: sv/gradient_ramp_runs.sv
// channel  direction  handshake                     payload
// stop     in         i_stop_valid / o_stop_ready   i_stop_position, i_stop_color, i_first_stop
// pixel    out        o_pixel_valid / i_pixel_ready o_pixel_index, o_pixel_color, o_last_of_run
// cfg      in         i_cfg_we                      i_cfg_data (ramp_length)
//
// A stop passes through the S_IDX and S_DECIDE setup states, then emits one pixel per cycle
// of a flat run (first stop, or an index not above the previous one) while the output is not
// stalled. Each interpolated pixel passes its four channels one at a time through the shared
// 8x6 multiplier and the 8-step restoring divider. One stop is in flight at a time.
// Reset is synchronous, active low; ramp_length returns to 64, previous stop to zero.
// A stalled pixel word holds in the output register and stalls the sequencer.
`default_nettype none

module gradient_ramp_runs (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_stop_valid,
    output logic                       o_stop_ready,
    input  wire grr_pkg::t_pos         i_stop_position,
    input  wire grr_pkg::t_col         i_stop_color,
    input  wire logic                  i_first_stop,
    output logic                       o_pixel_valid,
    input  wire logic                  i_pixel_ready,
    output grr_pkg::t_idx              o_pixel_index,
    output grr_pkg::t_col              o_pixel_color,
    output logic                       o_last_of_run,
    input  wire logic                  i_cfg_we,
    input  wire grr_pkg::t_len         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_DECIDE,
        S_MUL_A,
        S_MUL_B,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    grr_pkg::t_pos                   r_pos, n_pos;
    grr_pkg::t_col                   r_col, n_col;
    logic                            r_first, n_first;
    grr_pkg::t_idx                   r_idx, n_idx;
    grr_pkg::t_idx                   r_prev_idx, n_prev_idx;
    grr_pkg::t_col                   r_prev_col, n_prev_col;
    grr_pkg::t_idx                   r_x, n_x;
    grr_pkg::t_idx                   r_d, n_d;
    logic                            r_flat, n_flat;
    logic [grr_pkg::CH_SEL_W-1:0]    r_ch, n_ch;
    grr_pkg::t_num                   r_num, n_num;
    grr_pkg::t_col                   r_mix, n_mix;
    grr_pkg::t_len                   r_len;
    logic                            r_out_valid, n_out_valid;
    grr_pkg::t_idx                   r_out_index, n_out_index;
    grr_pkg::t_col                   r_out_color, n_out_color;
    logic                            r_out_last, n_out_last;

    grr_pkg::t_len                   w_eff;
    grr_pkg::t_idx                   wm1;
    grr_pkg::t_prod                  idx_sum;
    logic [grr_pkg::PROD_W-grr_pkg::FRAC_W-1:0] idx_raw;
    grr_pkg::t_idx                   idx_calc;
    grr_pkg::t_idx                   t_off;
    grr_pkg::t_ch                    mul_byte;
    grr_pkg::t_idx                   mul_fac;
    grr_pkg::t_num                   mul_prod;
    grr_pkg::t_div_req               div_req;
    grr_pkg::t_div_rsp               div_rsp;
    logic                            out_free;
    logic                            at_end;

    grr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_len == '0) begin
            w_eff = grr_pkg::LEN_MIN;
        end else if (r_len > grr_pkg::LEN_MAX) begin
            w_eff = grr_pkg::LEN_MAX;
        end else begin
            w_eff = r_len;
        end
    end

    assign wm1      = grr_pkg::IDX_W'(w_eff - grr_pkg::LEN_MIN);
    assign idx_sum  = grr_pkg::t_prod'(r_pos) * grr_pkg::t_prod'(wm1) + grr_pkg::HALF;
    assign idx_raw  = idx_sum[grr_pkg::PROD_W-1:grr_pkg::FRAC_W];
    assign idx_calc = (idx_raw > $bits(idx_raw)'(wm1)) ? wm1 : grr_pkg::IDX_W'(idx_raw);

    assign t_off    = r_x - r_prev_idx;
    assign mul_byte = (r_state == S_MUL_A) ? r_prev_col[r_ch*grr_pkg::CH_W +: grr_pkg::CH_W]
                                           : r_col[r_ch*grr_pkg::CH_W +: grr_pkg::CH_W];
    assign mul_fac  = (r_state == S_MUL_A) ? (r_d - t_off) : t_off;
    assign mul_prod = grr_pkg::t_num'(mul_byte) * grr_pkg::t_num'(mul_fac);

    assign div_req.start = (r_state == S_MUL_B);
    assign div_req.num   = r_num + mul_prod;
    assign div_req.den   = r_d;

    assign out_free = !r_out_valid || i_pixel_ready;
    assign at_end   = (r_x == r_idx);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_col       = r_col;
        n_first     = r_first;
        n_idx       = r_idx;
        n_prev_idx  = r_prev_idx;
        n_prev_col  = r_prev_col;
        n_x         = r_x;
        n_d         = r_d;
        n_flat      = r_flat;
        n_ch        = r_ch;
        n_num       = r_num;
        n_mix       = r_mix;
        n_out_valid = r_out_valid && !i_pixel_ready;
        n_out_index = r_out_index;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_stop_valid) begin
                    n_pos   = (i_stop_position > grr_pkg::POS_ONE) ? grr_pkg::POS_ONE
                                                                   : i_stop_position;
                    n_col   = i_stop_color;
                    n_first = i_first_stop;
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_idx   = idx_calc;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_ch = '0;
                if (r_first) begin
                    n_x     = '0;
                    n_flat  = 1'b1;
                    n_state = S_EMIT;
                end else if (r_idx <= r_prev_idx) begin
                    n_x     = r_idx;
                    n_flat  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_d     = r_idx - r_prev_idx;
                    n_x     = r_prev_idx + 1'b1;
                    n_flat  = 1'b0;
                    n_state = (r_prev_idx + 1'b1 == r_idx) ? S_EMIT : S_MUL_A;
                end
            end
            S_MUL_A: begin
                n_num   = mul_prod;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_mix[r_ch*grr_pkg::CH_W +: grr_pkg::CH_W] = div_rsp.quot;
                    n_ch = r_ch + 1'b1;
                    if (r_ch == grr_pkg::CH_SEL_W'(grr_pkg::NUM_CH - 1)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_x;
                    n_out_color = (r_flat || at_end) ? r_col : r_mix;
                    n_out_last  = at_end;
                    if (at_end) begin
                        n_prev_idx = r_idx;
                        n_prev_col = r_col;
                        n_state    = S_IDLE;
                    end else begin
                        n_x  = r_x + 1'b1;
                        n_ch = '0;
                        if (r_flat || (r_x + 1'b1 == r_idx)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_MUL_A;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_idx  <= '0;
            r_prev_col  <= '0;
            r_len       <= grr_pkg::LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_idx  <= n_prev_idx;
            r_prev_col  <= n_prev_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_col       <= n_col;
        r_first     <= n_first;
        r_idx       <= n_idx;
        r_x         <= n_x;
        r_d         <= n_d;
        r_flat      <= n_flat;
        r_ch        <= n_ch;
        r_num       <= n_num;
        r_mix       <= n_mix;
        r_out_index <= n_out_index;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_stop_ready  = (r_state == S_IDLE);
    assign o_pixel_valid = r_out_valid;
    assign o_pixel_index = r_out_index;
    assign o_pixel_color = r_out_color;
    assign o_last_of_run = r_out_last;

`ifndef SYNTHESIS
    a_x_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_x <= r_idx))
        else $error("pixel position past stop index");
    a_mix_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_A) |-> (r_d != '0 && r_x > r_prev_idx && r_x < r_idx))
        else $error("interpolation outside the open span");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("quotient arrived outside the wait state");
    a_index_in_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid |-> (o_pixel_index <= wm1))
        else $error("pixel index beyond ramp length");
`endif

endmodule

`default_nettype wire

FILE: sv/grr_div.sv
`default_nettype none

module grr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire grr_pkg::t_div_req i_req,
    output grr_pkg::t_div_rsp      o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [grr_pkg::STEP_W-1:0]     r_cnt;
    grr_pkg::t_idx                  r_rem;
    grr_pkg::t_ch                   r_low;
    grr_pkg::t_ch                   r_quot;
    grr_pkg::t_idx                  r_den;

    logic [grr_pkg::IDX_W:0]        trial;
    logic [grr_pkg::IDX_W:0]        diff;
    logic                           ge;

    assign trial = {r_rem, r_low[grr_pkg::CH_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == grr_pkg::STEP_W'(grr_pkg::CH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num[grr_pkg::NUM_W-1:grr_pkg::CH_W];
            r_low  <= i_req.num[grr_pkg::CH_W-1:0];
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[grr_pkg::IDX_W-1:0] : trial[grr_pkg::IDX_W-1:0];
            r_low  <= {r_low[grr_pkg::CH_W-2:0], 1'b0};
            r_quot <= {r_quot[grr_pkg::CH_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_den)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
